### design/ied_pkg.sv
package ied_pkg;

	typedef struct packed {
		logic signed [15:0] drive_axis;
		logic signed [15:0] turn_axis;
		logic               bumper_seen;
		logic               force_trigger;
		logic               signal_print_on;
		logic               registering_on;
		logic               is_calibrated;
	} ied_in_t;

	typedef struct packed {
		logic [1:0]  phase;
		logic        accident_found;
		logic        alert_out;
		logic        lab_report;
		logic [15:0] peak_g;
		logic [8:0]  impact_dir;
		logic        beep_long;
		logic        beep_short;
		logic        clear_motion;
	} ied_out_t;

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_OBS    = 2'd1;
	localparam logic [1:0] PH_HOLD   = 2'd2;
	localparam logic [1:0] PH_UNUSED = 2'd3;

	localparam logic [2:0] REG_ACC   = 3'd0;
	localparam logic [2:0] REG_START = 3'd1;
	localparam logic [2:0] REG_WIN   = 3'd2;
	localparam logic [2:0] REG_HOLD  = 3'd3;
	localparam logic [2:0] REG_LAB   = 3'd4;
	localparam logic [2:0] REG_BUZZ  = 3'd5;

	localparam int ANGLE_STEPS = 20;

	// atan(2^-i) in Q16 degrees
	function automatic logic [21:0] atan_q16(input logic [4:0] i);
		logic [21:0] r;
		unique case (i)
			5'd0:  r = 22'd2949120;
			5'd1:  r = 22'd1740967;
			5'd2:  r = 22'd919879;
			5'd3:  r = 22'd466945;
			5'd4:  r = 22'd234379;
			5'd5:  r = 22'd117304;
			5'd6:  r = 22'd58666;
			5'd7:  r = 22'd29335;
			5'd8:  r = 22'd14668;
			5'd9:  r = 22'd7334;
			5'd10: r = 22'd3667;
			5'd11: r = 22'd1833;
			5'd12: r = 22'd917;
			5'd13: r = 22'd458;
			5'd14: r = 22'd229;
			5'd15: r = 22'd115;
			5'd16: r = 22'd57;
			5'd17: r = 22'd29;
			5'd18: r = 22'd14;
			5'd19: r = 22'd7;
			default: r = 22'd0;
		endcase
		return r;
	endfunction

endpackage

### design/impact_event_detector_unit.sv
// Impact event detector: one request of two-axis acceleration plus flags
// gives one result. A request goes straight to the output state when the block
// is suspended or detection is off, through the decision state alone in holdoff
// without an alert, and through the magnitude path otherwise: a restoring square
// root that settles two radicand bits a cycle (a load step, then one digit step
// per root bit), a decision state and the output state. Working a hit angle adds
// a CORDIC load step, 20 rotations one a cycle, and a mapping step. One request
// is worked at a time; a new request is taken the cycle after the result is
// loaded, and while that result waits in the output register under a stalled
// receiver.
module impact_event_detector_unit #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  ied_pkg::ied_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output ied_pkg::ied_out_t out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import ied_pkg::*;

	localparam int PW    = 2 * SAMPLE_BITS;
	localparam int SQ_W  = 2 * SAMPLE_BITS + 2;
	localparam int SQ_IT = SQ_W / 2;

	typedef enum logic [2:0] {S_IDLE, S_SQRT, S_DECIDE, S_CORDIC, S_FINISH, S_OUT} st_t;

	st_t st_q;

	// configuration registers
	logic [11:0] acc_level_q;
	logic [14:0] start_level_q;
	logic [9:0]  win_q;
	logic [15:0] hold_q;
	logic        lab_q, buzz_q;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_level_q <= '0; start_level_q <= 15'd1000; win_q <= 10'd10;
			hold_q <= 16'd3000; lab_q <= 1'b0; buzz_q <= 1'b1;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[4:2])
				REG_ACC:   acc_level_q <= pwdata[11:0];
				REG_START: start_level_q <= pwdata[14:0];
				REG_WIN:   win_q <= pwdata[9:0];
				REG_HOLD:  hold_q <= pwdata[15:0];
				REG_LAB:   lab_q <= pwdata[0];
				REG_BUZZ:  buzz_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_ACC:   prdata = {20'd0, acc_level_q};
			REG_START: prdata = {17'd0, start_level_q};
			REG_WIN:   prdata = {22'd0, win_q};
			REG_HOLD:  prdata = {16'd0, hold_q};
			REG_LAB:   prdata = {31'd0, lab_q};
			REG_BUZZ:  prdata = {31'd0, buzz_q};
			default:   prdata = '0;
		endcase
	end

	// block state
	logic [1:0]  phase_q;
	logic [15:0] cnt_q, peak_q;
	logic signed [SAMPLE_BITS-1:0] pd_q, pt_q;
	logic [8:0]  angle_q;

	// request latch
	logic signed [SAMPLE_BITS-1:0] d_q, t_q;
	logic bump_q, trig_q;

	// square root datapath
	logic [SQ_W-1:0] rad_q;
	logic [SAMPLE_BITS:0] root_q;
	logic [SAMPLE_BITS+2:0] rem_q;
	logic [5:0] it_q;

	// cordic datapath: sign-magnitude inputs scaled by 2^20
	localparam int CW = SAMPLE_BITS + 23;
	logic signed [CW-1:0] cx_q, cy_q;
	logic signed [23:0] cz_q;
	logic [4:0] ci_q;
	logic c_neg_d, c_pos_t, c_neg_t;
	logic c_zero_t_q, c_eq_q, cd_neg_q, ct_pos_q, ct_neg_q;
	logic ang_from_peak_q;

	// pending result flags
	logic found_q, alert_q, lab_r_q, blong_q, bshort_q, clr_q;

	assign in_stall = (st_q != S_IDLE);

	logic [SAMPLE_BITS-1:0] ad, at;
	always_comb begin
		ad = d_q[SAMPLE_BITS-1] ? SAMPLE_BITS'(-d_q) : d_q;
		at = t_q[SAMPLE_BITS-1] ? SAMPLE_BITS'(-t_q) : t_q;
	end

	// squares of the axis magnitudes
	logic [PW-1:0] sq_d, sq_t;
	always_comb begin
		sq_d = PW'(ad) * PW'(ad);
		sq_t = PW'(at) * PW'(at);
	end

	// sqrt step
	logic [SAMPLE_BITS+2:0] trial;
	logic [SAMPLE_BITS+2:0] rem_sh;
	always_comb begin
		rem_sh = {rem_q[SAMPLE_BITS:0], rad_q[SQ_W-1 -: 2]};
		trial  = {root_q, 2'b01};
	end

	logic susp;
	assign susp = in_data.signal_print_on || in_data.registering_on ||
		!in_data.is_calibrated || (acc_level_q == '0);

	// cordic step
	logic signed [CW-1:0] xs, ys;
	always_comb begin
		xs = cx_q >>> ci_q;
		ys = cy_q[CW-1] ? -((-cy_q) >>> ci_q) : (cy_q >>> ci_q);
	end

	logic signed [SAMPLE_BITS-1:0] ang_d, ang_t;
	logic [SAMPLE_BITS-1:0] am, an;
	logic [16:0] root_n;
	always_comb begin
		root_n = 17'(root_q);
		ang_d = ang_from_peak_q ? pd_q : d_q;
		ang_t = ang_from_peak_q ? pt_q : t_q;
		if (ang_d == '0) ang_d = SAMPLE_BITS'(1);
		am = ang_d[SAMPLE_BITS-1] ? SAMPLE_BITS'(-ang_d) : ang_d;
		an = ang_t[SAMPLE_BITS-1] ? SAMPLE_BITS'(-ang_t) : ang_t;
		c_neg_d = ang_d[SAMPLE_BITS-1];
		c_pos_t = !ang_t[SAMPLE_BITS-1] && (ang_t != '0);
		c_neg_t = ang_t[SAMPLE_BITS-1];
	end

	logic signed [25:0] zc, vv;
	always_comb begin
		if (c_zero_t_q) zc = '0;
		else if (c_eq_q) zc = 26'sd2949120;
		else if (cz_q < 0) zc = '0;
		else if (26'(cz_q) > 26'sd5898239) zc = 26'sd5898239;
		else zc = 26'(cz_q);
		if (cd_neg_q) vv = ct_pos_q ? 26'sd23592960 - zc : zc;
		else vv = ct_neg_q ? 26'sd11796480 - zc : 26'sd11796480 + zc;
	end

	logic [15:0] cnt_inc;
	assign cnt_inc = cnt_q + 16'd1;

	// decision terms for the current sample
	logic [15:0] root16, peak_now;
	logic new_peak, win_end, start_ok;
	always_comb begin
		root16 = root_n[15:0];
		new_peak = root16 > peak_q;
		peak_now = new_peak ? root16 : peak_q;
		win_end = cnt_inc >= 16'(win_q);
		start_ok = !bump_q && (at >= 16'(start_level_q) ||
			ad >= 16'(start_level_q) || trig_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; out_valid <= 1'b0; out_data <= '0;
			phase_q <= PH_IDLE; cnt_q <= '0; peak_q <= '0;
			pd_q <= '0; pt_q <= '0; angle_q <= '0;
			d_q <= '0; t_q <= '0; bump_q <= 1'b0; trig_q <= 1'b0;
			rad_q <= '0; root_q <= '0; rem_q <= '0; it_q <= '0;
			cx_q <= '0; cy_q <= '0; cz_q <= '0; ci_q <= '0;
			c_zero_t_q <= 1'b0; c_eq_q <= 1'b0; cd_neg_q <= 1'b0;
			ct_pos_q <= 1'b0; ct_neg_q <= 1'b0; ang_from_peak_q <= 1'b0;
			{found_q, alert_q, lab_r_q, blong_q, bshort_q, clr_q} <= '0;
		end else begin
			if (out_valid && !out_stall && st_q != S_OUT) out_valid <= 1'b0;
			unique case (st_q)
				S_IDLE: if (in_valid && !in_stall) begin
					d_q <= in_data.drive_axis[SAMPLE_BITS-1:0];
					t_q <= in_data.turn_axis[SAMPLE_BITS-1:0];
					bump_q <= in_data.bumper_seen;
					trig_q <= in_data.force_trigger;
					{found_q, alert_q, lab_r_q, blong_q, bshort_q, clr_q} <= '0;
					if (susp) begin
						st_q <= S_OUT;
					end else if (phase_q == PH_HOLD) begin
						st_q <= S_DECIDE;
					end else if (phase_q == PH_UNUSED) begin
						phase_q <= PH_IDLE; st_q <= S_OUT;
					end else begin
						st_q <= S_SQRT;
						it_q <= '0; root_q <= '0; rem_q <= '0;
					end
				end
				S_SQRT: begin
					// first cycle loads the sum of squares; later cycles take digits
					if (it_q == '0) begin
						rad_q <= SQ_W'(sq_d) + SQ_W'(sq_t);
						it_q <= 6'd1;
					end else begin
						rad_q <= rad_q << 2;
						if (rem_sh >= trial) begin
							rem_q <= rem_sh - trial;
							root_q <= {root_q[SAMPLE_BITS-1:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							root_q <= {root_q[SAMPLE_BITS-1:0], 1'b0};
						end
						if (it_q == 6'(SQ_IT)) st_q <= S_DECIDE;
						it_q <= it_q + 6'd1;
					end
				end
				S_DECIDE: begin
					ci_q <= 5'd31;
					if (phase_q == PH_OBS) begin
						cnt_q <= cnt_inc;
						ang_from_peak_q <= 1'b1;
						if (new_peak) begin
							peak_q <= root16; pd_q <= d_q; pt_q <= t_q;
						end
						if (win_end && lab_q) begin
							lab_r_q <= 1'b1; phase_q <= PH_IDLE; st_q <= S_CORDIC;
						end else if (win_end &&
								(peak_now >= 16'(acc_level_q) * 16'd10 || trig_q)) begin
							phase_q <= PH_HOLD; found_q <= 1'b1; st_q <= S_OUT;
						end else begin
							// bumper or a quiet window ends observation
							if (win_end || bump_q) phase_q <= PH_IDLE;
							st_q <= S_OUT;
						end
					end else if (phase_q == PH_HOLD) begin
						clr_q <= 1'b1;
						cnt_q <= cnt_inc;
						ang_from_peak_q <= 1'b1;
						if (cnt_q == 16'(win_q)) begin
							alert_q <= 1'b1; blong_q <= buzz_q; st_q <= S_CORDIC;
						end else begin
							st_q <= S_OUT;
						end
						if (cnt_inc >= hold_q) begin
							phase_q <= PH_IDLE; bshort_q <= buzz_q;
						end
					end else if (start_ok) begin
						phase_q <= PH_OBS; cnt_q <= 16'd1;
						pd_q <= d_q; pt_q <= t_q; peak_q <= root16;
						ang_from_peak_q <= 1'b0; st_q <= S_CORDIC;
					end else begin
						st_q <= S_OUT;
					end
				end
				S_CORDIC: begin
					if (ci_q == 5'd31) begin
						// load from sign-magnitude operands
						cx_q <= CW'({am, 20'd0}); cy_q <= CW'({an, 20'd0});
						cz_q <= '0; ci_q <= '0;
						c_zero_t_q <= (an == '0); c_eq_q <= (an == am);
						cd_neg_q <= c_neg_d; ct_pos_q <= c_pos_t; ct_neg_q <= c_neg_t;
					end else begin
						if (!cy_q[CW-1]) begin
							cx_q <= cx_q + ys; cy_q <= cy_q - xs;
							cz_q <= cz_q + 24'(atan_q16(ci_q));
						end else begin
							cx_q <= cx_q - ys; cy_q <= cy_q + xs;
							cz_q <= cz_q - 24'(atan_q16(ci_q));
						end
						if (ci_q == 5'(ANGLE_STEPS - 1)) st_q <= S_FINISH;
						ci_q <= ci_q + 5'd1;
					end
				end
				S_FINISH: begin
					angle_q <= (vv[25:16] > 10'sd359) ? 9'd359 : vv[24:16];
					st_q <= S_OUT;
				end
				S_OUT: if (!out_valid || !out_stall) begin
					out_valid <= 1'b1;
					out_data.phase <= phase_q;
					out_data.accident_found <= found_q;
					out_data.alert_out <= alert_q;
					out_data.lab_report <= lab_r_q;
					out_data.peak_g <= peak_q;
					out_data.impact_dir <= angle_q;
					out_data.beep_long <= blong_q;
					out_data.beep_short <= bshort_q;
					out_data.clear_motion <= clr_q;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

### design/ied_checker.sv
module ied_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input ied_pkg::ied_out_t out_data
);
	import ied_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result dropped or changed under stall");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request taken while busy");
	a_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.phase != PH_UNUSED)
		else $error("bad phase");
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.accident_found |-> out_data.phase == PH_HOLD)
		else $error("accident without holdoff");
endmodule

bind impact_event_detector_unit ied_checker u_chk (.*);

### tb/sv/testbench.sv
module testbench;
	import ied_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	ied_in_t     in_data;
	logic        out_valid;
	logic        out_stall;
	ied_out_t    out_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	impact_event_detector_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// shadow of the configuration
	int unsigned cfg_acc_level, cfg_start_level, cfg_window, cfg_holdoff;
	bit          cfg_lab, cfg_buzz;

	// shadow of the detector state
	logic [1:0]  det_phase;
	logic [15:0] det_count;
	int unsigned det_peak;
	int          det_peak_d, det_peak_t;
	int unsigned det_angle;

	ied_out_t    expected_results[$];
	int          errors;
	bit          quiet_tx;     // sender offers back to back
	bit          quiet_rx;     // receiver never stalls at random
	int          rx_hold_left; // long receiver hold-off in cycles

	localparam longint DEG_Q = 65536;
	localparam longint ATAN_TAB[20] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
	};

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#20000000;
		$display("** impact_event_detector_unit: FAILED **");
		$finish;
	end

	// ---------------- prediction ----------------

	function automatic int unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return int'(r);
	endfunction

	function automatic int unsigned accel_mag(int d, int t);
		longint unsigned s;
		s = longint'(d) * d + longint'(t) * t;
		return int_sqrt(s);
	endfunction

	function automatic longint shift_toward_zero(longint v, int s);
		if (v >= 0) return v >>> s;
		return -((-v) >>> s);
	endfunction

	// CORDIC vectoring, then quadrant mapping to 0..359 degrees
	function automatic int unsigned impact_angle(int d, int t);
		longint m, n, x, y, z, v, xs, ys;
		z = 0;
		if (d == 0) d = 1;
		m = (d < 0) ? -longint'(d) : longint'(d);
		n = (t < 0) ? -longint'(t) : longint'(t);
		if (n == 0) begin
			z = 0;
		end else if (n == m) begin
			z = 45 * DEG_Q;
		end else begin
			x = m <<< 20;
			y = n <<< 20;
			for (int i = 0; i < 20; i++) begin
				xs = x >>> i;
				ys = shift_toward_zero(y, i);
				if (y >= 0) begin
					x += ys; y -= xs; z += ATAN_TAB[i];
				end else begin
					x -= ys; y += xs; z -= ATAN_TAB[i];
				end
			end
			if (z < 0) z = 0;
			if (z > 90 * DEG_Q - 1) z = 90 * DEG_Q - 1;
		end
		if (d < 0) v = (t > 0) ? 360 * DEG_Q - z : z;
		else v = (t >= 0) ? 180 * DEG_Q + z : 180 * DEG_Q - z;
		v = v >>> 16;
		if (v > 359) v = 359;
		return int'(v);
	endfunction

	function automatic ied_out_t predict_impact(ied_in_t x);
		ied_out_t    r;
		int          d, t;
		int unsigned mag;
		bit          halted;
		d = x.drive_axis;
		t = x.turn_axis;
		r = '0;
		halted = x.signal_print_on || x.registering_on || !x.is_calibrated
			|| cfg_acc_level == 0;
		if (!halted) begin
			case (det_phase)
				PH_OBS: begin
					mag = accel_mag(d, t);
					det_count = det_count + 16'd1;
					if (mag > det_peak) begin
						det_peak = mag; det_peak_d = d; det_peak_t = t;
					end
					if (x.bumper_seen) det_phase = PH_IDLE;
					if (det_count >= cfg_window) begin
						if (cfg_lab) begin
							det_angle = impact_angle(det_peak_d, det_peak_t);
							r.lab_report = 1'b1;
							det_phase = PH_IDLE;
						end else if (det_peak >= cfg_acc_level * 10 || x.force_trigger) begin
							det_phase = PH_HOLD;
							r.accident_found = 1'b1;
						end else begin
							det_phase = PH_IDLE;
						end
					end
				end
				PH_HOLD: begin
					r.clear_motion = 1'b1;
					if (det_count == cfg_window) begin
						det_angle = impact_angle(det_peak_d, det_peak_t);
						r.alert_out = 1'b1;
						r.beep_long = cfg_buzz;
					end
					det_count = det_count + 16'd1;
					if (det_count >= cfg_holdoff) begin
						det_phase = PH_IDLE;
						r.beep_short = cfg_buzz;
					end
				end
				PH_IDLE: begin
					if (!x.bumper_seen && ((t < 0 ? -t : t) >= cfg_start_level
						|| (d < 0 ? -d : d) >= cfg_start_level || x.force_trigger)) begin
						det_phase = PH_OBS;
						det_count = 16'd1;
						det_peak_d = d; det_peak_t = t;
						det_peak = accel_mag(d, t);
						det_angle = impact_angle(d, t);
					end
				end
				default: det_phase = PH_IDLE;
			endcase
		end
		r.phase = det_phase;
		r.peak_g = det_peak[15:0];
		r.impact_dir = det_angle[8:0];
		return r;
	endfunction

	// ---------------- configuration port ----------------

	task automatic write_reg(logic [2:0] idx, int unsigned val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_ACC:   cfg_acc_level = val & 32'hFFF;
			REG_START: cfg_start_level = val & 32'h7FFF;
			REG_WIN:   cfg_window = val & 32'h3FF;
			REG_HOLD:  cfg_holdoff = val & 32'hFFFF;
			REG_LAB:   cfg_lab = val[0];
			REG_BUZZ:  cfg_buzz = val[0];
			default: ;
		endcase
	endtask

	// block idle: no request offered, all results in, then room for any work in flight
	task automatic drain;
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic set_detector(int unsigned acc, int unsigned st, int unsigned win,
			int unsigned hold, bit lab, bit buzz);
		drain();
		write_reg(REG_ACC, acc);
		write_reg(REG_START, st);
		write_reg(REG_WIN, win);
		write_reg(REG_HOLD, hold);
		write_reg(REG_LAB, lab);
		write_reg(REG_BUZZ, buzz);
	endtask

	// ---------------- request side ----------------

	function automatic int gap_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (quiet_tx || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_request(ied_in_t x);
		int  gap;
		bit  taken;
		gap = gap_cycles();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= x;
		forever begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
			if (taken) break;
		end
		expected_results.push_back(predict_impact(x));
	endtask

	function automatic ied_in_t sample_req(int d, int t, bit bump, bit trig);
		ied_in_t x;
		x = '0;
		x.drive_axis = d[15:0];
		x.turn_axis = t[15:0];
		x.bumper_seen = bump;
		x.force_trigger = trig;
		x.is_calibrated = 1'b1;
		return x;
	endfunction

	function automatic int rand_axis();
		int r, v;
		r = $urandom_range(0, 99);
		if (r < 30) v = $urandom_range(0, 400) - 200;
		else if (r < 55) v = int'(cfg_start_level) + $urandom_range(0, 100) - 50;
		else if (r < 85) v = $signed(16'($urandom));
		else begin
			case ($urandom_range(0, 3))
				0: v = -32768;
				1: v = 32767;
				2: v = 0;
				default: v = -1;
			endcase
		end
		if (r >= 30 && r < 55 && $urandom_range(0, 1)) v = -v;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v;
	endfunction

	function automatic ied_in_t rand_req();
		ied_in_t x;
		x = sample_req(rand_axis(), rand_axis(), $urandom_range(0, 99) < 5,
			$urandom_range(0, 99) < 5);
		if ($urandom_range(0, 99) < 6) begin
			case ($urandom_range(0, 2))
				0: x.signal_print_on = 1'b1;
				1: x.registering_on = 1'b1;
				default: x.is_calibrated = 1'b0;
			endcase
		end
		return x;
	endfunction

	// ---------------- result side ----------------

	always @(posedge clk) begin
		if (rx_hold_left > 0) begin
			out_stall <= 1'b1;
			rx_hold_left <= rx_hold_left - 1;
		end else if (quiet_rx) begin
			out_stall <= 1'b0;
		end else if ($urandom_range(0, 99) < 3) begin
			out_stall <= 1'b1;
			rx_hold_left <= $urandom_range(10, 40);
		end else begin
			out_stall <= ($urandom_range(0, 99) < 25);
		end
	end

	task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// compare each result with the oldest prediction
	initial begin
		ied_out_t got, want;
		bit       fire;
		forever begin
			@(negedge clk);
			fire = out_valid && !out_stall;
			got = out_data;
			@(posedge clk);
			if (fire) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %h", $time, got);
					errors++;
				end else begin
					want = expected_results.pop_front();
					check_field("phase", want.phase, got.phase);
					check_field("accident_found", want.accident_found, got.accident_found);
					check_field("alert_out", want.alert_out, got.alert_out);
					check_field("lab_report", want.lab_report, got.lab_report);
					check_field("peak_g", want.peak_g, got.peak_g);
					check_field("impact_dir", want.impact_dir, got.impact_dir);
					check_field("beep_long", want.beep_long, got.beep_long);
					check_field("beep_short", want.beep_short, got.beep_short);
					check_field("clear_motion", want.clear_motion, got.clear_motion);
				end
			end
		end
	end

	// ---------------- tests ----------------

	task automatic test_directed;
		ied_in_t x;
		// detection disabled at reset
		send_request(sample_req(5000, 0, 0, 0));
		set_detector(100, 1000, 3, 6, 0, 1);
		// each suspend source
		x = sample_req(32767, 0, 0, 0); x.signal_print_on = 1'b1; send_request(x);
		x = sample_req(32767, 0, 0, 0); x.registering_on = 1'b1; send_request(x);
		x = sample_req(32767, 0, 0, 0); x.is_calibrated = 1'b0; send_request(x);
		// below start, then bumper blocking a start
		send_request(sample_req(10, -10, 0, 0));
		send_request(sample_req(32767, 0, 1, 0));
		// largest magnitude opens window, accident, full holdoff with alert
		send_request(sample_req(32767, -32768, 0, 0));
		send_request(sample_req(0, 5, 0, 0));
		send_request(sample_req(-100, 100, 0, 0));
		repeat (3) send_request(sample_req(1, 1, 0, 0));
		// trigger forces start and accident
		send_request(sample_req(0, 0, 0, 1));
		send_request(sample_req(0, -1000, 0, 0));
		send_request(sample_req(3, 0, 0, 1));
		repeat (3) send_request(sample_req(0, 0, 0, 0));
		// bumper cancels an open window
		send_request(sample_req(-1500, 0, 0, 0));
		send_request(sample_req(0, 0, 1, 0));
		// bumper on the deciding sample: still decided
		send_request(sample_req(1200, 1200, 0, 0));
		send_request(sample_req(5, -7, 0, 0));
		send_request(sample_req(-2, 9, 1, 0));
		repeat (3) send_request(sample_req(0, 0, 0, 0));
	endtask

	task automatic test_random_run(int n);
		for (int i = 0; i < n; i++) begin
			if (i % 60 == 0) begin
				quiet_tx = ($urandom_range(0, 3) == 0);
				quiet_rx = ($urandom_range(0, 3) == 0);
			end
			send_request(rand_req());
		end
		quiet_tx = 0;
		quiet_rx = 0;
	endtask

	task automatic test_random_settings;
		set_detector($urandom_range(50, 300), 1000, 4, 12, 0, 1);
		test_random_run(150);
		set_detector(4095, 0, 1, 1, 0, 0);
		test_random_run(120);
		set_detector(1, 32767, 5, 20, 0, 1);
		test_random_run(120);
		set_detector($urandom_range(1, 400), $urandom_range(200, 3000), 6, 30, 1, 1);
		test_random_run(150);
		set_detector(200, 500, 1023, 1040, 1, 0);
		test_random_run(150);
		set_detector(150, 800, 3, 65535, 0, 1);
		test_random_run(120);
		// window shortened while held off: alert can be skipped
		set_detector(150, 800, 2, 65535, 0, 1);
		test_random_run(60);
		set_detector($urandom_range(1, 4095), $urandom_range(0, 32767),
			$urandom_range(1, 12), $urandom_range(1, 40), $urandom_range(0, 1),
			$urandom_range(0, 1));
		test_random_run(250);
	endtask

	task automatic test_receiver_holdoff;
		set_detector(100, 300, 3, 8, 0, 1);
		quiet_tx = 1;
		// set between edges so the receiver process picks it up cleanly
		@(negedge clk);
		rx_hold_left = 400;
		@(posedge clk);
		for (int i = 0; i < 40; i++) send_request(rand_req());
		quiet_tx = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0; in_data = '0;
		out_stall = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		errors = 0; quiet_tx = 0; quiet_rx = 0; rx_hold_left = 0;
		cfg_acc_level = 0; cfg_start_level = 1000; cfg_window = 10;
		cfg_holdoff = 3000; cfg_lab = 0; cfg_buzz = 1;
		det_phase = PH_IDLE; det_count = '0; det_peak = 0;
		det_peak_d = 0; det_peak_t = 0; det_angle = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_settings();
		test_receiver_holdoff();

		drain();
		if (errors == 0) begin
			$display("** impact_event_detector_unit: PASSED **");
		end else begin
			$display("** impact_event_detector_unit: FAILED **");
		end
		$finish;
	end

endmodule
